>>> rtl/core/servo_bus_packet_receiver_macros.svh
// ----------------------------------------------------------------------------
// Servo bus packet receiver assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during rst_ni.
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_PACKET_RECEIVER_MACROS_SVH
`define SERVO_BUS_PACKET_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SBPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define SBPR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SBPR_ASSERT(lbl, prop, msg)
`define SBPR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/core/sbpr_pkg.sv
// ----------------------------------------------------------------------------
// Servo bus packet receiver package
// Beat types, configuration types and protocol constants.
// ----------------------------------------------------------------------------
package sbpr_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [8:0] FRAME_EXTRA = 9'd4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID       = 2'd0,
    CFG_BROADCAST_ID = 2'd1,
    CFG_MAX_PACKET   = 2'd2,
    CFG_TIMEOUT      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_BODY     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_CSUM_ERR = 3'd2,
    KIND_OVERSIZE = 3'd3,
    KIND_TIMEOUT  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0]  own_id;
    logic [7:0]  broadcast_id;
    logic [8:0]  max_packet_bytes;
    logic [15:0] byte_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] packet_id;
    logic [7:0] instruction;
    logic [7:0] body_index;
    logic [7:0] data;
    logic [7:0] body_length;
  } out_beat_t;

endpackage

>>> rtl/core/sbpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Servo bus packet receiver configuration registers
// Holds the ID, size and timeout settings written through the config port.
// ----------------------------------------------------------------------------
module sbpr_cfg_regs import sbpr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_ID:       cfg_d.own_id             = cfg_wdata_i[7:0];
        CFG_BROADCAST_ID: cfg_d.broadcast_id       = cfg_wdata_i[7:0];
        CFG_MAX_PACKET:   cfg_d.max_packet_bytes   = cfg_wdata_i[8:0];
        CFG_TIMEOUT:      cfg_d.byte_timeout_ticks = cfg_wdata_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id             <= 8'd1;
      cfg_q.broadcast_id       <= 8'd254;
      cfg_q.max_packet_bytes   <= 9'd255;
      cfg_q.byte_timeout_ticks <= 16'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/servo_bus_packet_receiver.sv
// ----------------------------------------------------------------------------
// Servo bus packet receiver
// Parses protocol 1 style servo bus packets: header hunt, length, body stream,
// checksum verdict, oversize drop and inter-byte timeout.
// ----------------------------------------------------------------------------
// Each input beat is either a received bus byte or a one millisecond tick. The
// parser state is updated in the cycle the beat is accepted, and the zero or
// one result it causes is loaded into a single output register in the same
// edge. A new beat is accepted every cycle as long as that output register is
// empty or being drained; while a result sits stalled at the output, the
// input is stalled too. Results appear in the cycle after the beat that caused
// them. There is no start-up sequence after reset.
`include "servo_bus_packet_receiver_macros.svh"

module servo_bus_packet_receiver import sbpr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  cfg_t cfg;

  sbpr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Only the two most recent header bytes matter: the oldest byte of the
  // window is shifted out before it could ever be compared.
  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_prev_q, hdr_prev_d;
  logic [7:0]  hdr_last_q, hdr_last_d;
  logic [8:0]  byte_cnt_q, byte_cnt_d;
  logic [8:0]  total_len_q, total_len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  held_id_q, held_id_d;
  logic [7:0]  held_instr_q, held_instr_d;
  logic [7:0]  held_len_q, held_len_d;
  logic [15:0] idle_q, idle_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_data_q, out_data_d;

  logic        in_acc;
  logic        out_take;
  logic        emit;
  kind_e       emit_kind;
  logic [7:0]  emit_index;
  logic [7:0]  emit_data;
  logic [7:0]  b;
  logic [15:0] idle_inc;
  logic [8:0]  len_total;
  logic [8:0]  cnt_next;
  logic [8:0]  body_pos;
  logic [7:0]  sum_next;

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign b         = in_data_i.data_byte;
  assign idle_inc  = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign len_total = {1'b0, b} + FRAME_EXTRA;
  assign cnt_next  = byte_cnt_q + 9'd1;
  assign body_pos  = byte_cnt_q - FRAME_EXTRA;
  assign sum_next  = sum_q + b;

  always_comb begin
    phase_d      = phase_q;
    hdr_prev_d   = hdr_prev_q;
    hdr_last_d   = hdr_last_q;
    byte_cnt_d   = byte_cnt_q;
    total_len_d  = total_len_q;
    sum_d        = sum_q;
    held_id_d    = held_id_q;
    held_instr_d = held_instr_q;
    held_len_d   = held_len_q;
    idle_d       = idle_q;
    emit         = 1'b0;
    emit_kind    = KIND_BODY;
    emit_index   = 8'd0;
    emit_data    = 8'd0;

    if (in_acc) begin
      if (in_data_i.op) begin
        idle_d = idle_inc;
        if (phase_q != PH_HUNT && idle_inc > cfg.byte_timeout_ticks) begin
          emit        = 1'b1;
          emit_kind   = KIND_TIMEOUT;
          phase_d     = PH_HUNT;
          byte_cnt_d  = 9'd0;
          total_len_d = 9'd0;
        end
      end else begin
        idle_d = 16'd0;
        unique case (phase_q)
          PH_HUNT: begin
            if (hdr_prev_q == SYNC_BYTE && hdr_last_q == SYNC_BYTE &&
                (b == cfg.own_id || b == cfg.broadcast_id)) begin
              held_id_d    = b;
              held_instr_d = 8'd0;
              held_len_d   = 8'd0;
              sum_d        = b;
              byte_cnt_d   = 9'd3;
              total_len_d  = 9'd0;
              hdr_prev_d   = 8'd0;
              hdr_last_d   = 8'd0;
              phase_d      = PH_LEN;
            end else begin
              hdr_prev_d = hdr_last_q;
              hdr_last_d = b;
            end
          end
          PH_LEN: begin
            held_len_d  = b;
            sum_d       = sum_next;
            byte_cnt_d  = FRAME_EXTRA;
            total_len_d = len_total;
            if (len_total > cfg.max_packet_bytes) begin
              emit        = 1'b1;
              emit_kind   = KIND_OVERSIZE;
              phase_d     = PH_HUNT;
              byte_cnt_d  = 9'd0;
              total_len_d = 9'd0;
            end else begin
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            sum_d      = sum_next;
            byte_cnt_d = cnt_next;
            emit       = 1'b1;
            emit_index = body_pos[7:0];
            emit_data  = b;
            if (cnt_next >= total_len_q) begin
              emit_kind   = (sum_next == SYNC_BYTE) ? KIND_OK : KIND_CSUM_ERR;
              phase_d     = PH_HUNT;
              byte_cnt_d  = 9'd0;
              total_len_d = 9'd0;
            end else if (body_pos[7:0] == 8'd0) begin
              held_instr_d = b;
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end
  end

  // The result reports the held fields as they stand after this beat.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_acc && emit) begin
      out_valid_d            = 1'b1;
      out_data_d.kind        = emit_kind;
      out_data_d.packet_id   = held_id_d;
      out_data_d.instruction = held_instr_d;
      out_data_d.body_index  = emit_index;
      out_data_d.data        = emit_data;
      out_data_d.body_length = held_len_d;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      hdr_prev_q   <= 8'd0;
      hdr_last_q   <= 8'd0;
      byte_cnt_q   <= 9'd0;
      total_len_q  <= 9'd0;
      sum_q        <= 8'd0;
      held_id_q    <= 8'd0;
      held_instr_q <= 8'd0;
      held_len_q   <= 8'd0;
      idle_q       <= 16'd0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_prev_q   <= hdr_prev_d;
      hdr_last_q   <= hdr_last_d;
      byte_cnt_q   <= byte_cnt_d;
      total_len_q  <= total_len_d;
      sum_q        <= sum_d;
      held_id_q    <= held_id_d;
      held_instr_q <= held_instr_d;
      held_len_q   <= held_len_d;
      idle_q       <= idle_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SBPR_ASSERT(a_hunt_counts_clear, (phase_q == PH_HUNT) |-> (byte_cnt_q == 9'd0 && total_len_q == 9'd0), "byte count or total length left over while hunting")
  `SBPR_ASSERT(a_body_count_range, (phase_q == PH_BODY) |-> (byte_cnt_q >= FRAME_EXTRA && byte_cnt_q <= total_len_q), "body byte count outside the packet")
  `SBPR_ASSERT(a_byte_clears_idle, (in_acc && !in_data_i.op) |=> (idle_q == 16'd0), "idle tick count not cleared by a byte")
  `SBPR_ASSERT(a_body_result_in_body, (out_valid_q && out_data_q.kind == KIND_BODY) |-> (phase_q == PH_BODY), "body result pending outside the body phase")
  `SBPR_ASSERT_NEVER(a_no_accept_when_full, in_acc && out_valid_q && out_stall_i, "beat accepted while a result is stalled")

endmodule
